[src/smseq_pkg.sv]
// Package for the stepper move sequencer: field widths, codes, reset values,
// the full-step coil table and the result word layout.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package smseq_pkg;

  // Field widths of the input and result words.
  localparam int KIND_W     = 2;
  localparam int AXIS_W     = 2;
  localparam int DIST_W     = 24;
  localparam int DUR_W      = 20;
  localparam int STATUS_W   = 3;
  localparam int FIRED_W    = 3;
  localparam int COIL_W     = 4;
  localparam int MSTEPS_W   = 24;
  localparam int IV_W       = 30;
  localparam int OUT_AXES   = 3;

  // Configuration port.
  localparam int SPM_W      = 8;
  localparam int US_W       = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_BELOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd2;

  localparam logic [SPM_W-1:0] SPM_RESET    = 8'd25;
  localparam logic [US_W-1:0]  REJECT_RESET = 20'd9000;
  localparam logic [US_W-1:0]  MIN_RESET    = 20'd10000;

  // Datapath widths. The product of a 24-bit magnitude and an 8-bit scale stays
  // below 2^31, so the rounded step count fits in 24 bits.
  localparam int PROD_W     = 32;
  localparam int FRAC_BITS  = 8;
  localparam int STEPS_W    = PROD_W - FRAC_BITS;
  localparam int N_W        = 30;
  localparam int DVD_W      = 32;
  localparam int DVS_W      = STEPS_W + 1;
  localparam int DIV_CNT_W  = 5;
  localparam int PHASE_W    = 2;

  localparam logic [PROD_W-1:0] ROUND_BIAS = 32'd127;
  localparam logic [N_W-1:0]    US_PER_MS  = 30'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_MOVE    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STEP     = 3'd0,
    STAT_ACCEPTED = 3'd1,
    STAT_ZERO     = 3'd2,
    STAT_TOO_FAST = 3'd3,
    STAT_BUSY     = 3'd4,
    STAT_RELEASED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_RELEASE,
    S_MULT,
    S_SCALE,
    S_DIV,
    S_DECIDE
  } state_t;

  typedef struct packed {
    status_t                             status;
    logic [FIRED_W-1:0]                  fired;
    logic [OUT_AXES-1:0][COIL_W-1:0]     coils;
    logic [MSTEPS_W-1:0]                 steps;
    logic [IV_W-1:0]                     interval;
    logic                                last;
  } res_t;

  // Full-step two-phase pattern for each phase, coils a,b,c,d from msb down.
  function automatic logic [COIL_W-1:0] coil_of_phase(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      2'd0:    pat = 4'b1010;
      2'd1:    pat = 4'b0110;
      2'd2:    pat = 4'b0101;
      2'd3:    pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[src/smseq_in_if.sv]
// Input channel of the stepper move sequencer: valid/ready plus the item fields.
// Depends on smseq_pkg for the field widths.
`default_nettype none

interface smseq_in_if;
  logic                                valid;
  logic                                ready;
  logic [smseq_pkg::KIND_W-1:0]        kind;
  logic [smseq_pkg::AXIS_W-1:0]        axis;
  logic signed [smseq_pkg::DIST_W-1:0] distance_q8;
  logic [smseq_pkg::DUR_W-1:0]         duration_ms;

  modport source (output valid, kind, axis, distance_q8, duration_ms, input ready);
  modport sink   (input valid, kind, axis, distance_q8, duration_ms, output ready);
endinterface

`default_nettype wire

[src/smseq_out_if.sv]
// Result channel of the stepper move sequencer: valid/ready plus the result fields.
// Depends on smseq_pkg for the field widths.
`default_nettype none

interface smseq_out_if;
  logic                           valid;
  logic                           ready;
  logic [smseq_pkg::STATUS_W-1:0] status;
  logic [smseq_pkg::FIRED_W-1:0]  fired_mask;
  logic [smseq_pkg::COIL_W-1:0]   coils_x;
  logic [smseq_pkg::COIL_W-1:0]   coils_y;
  logic [smseq_pkg::COIL_W-1:0]   coils_z;
  logic [smseq_pkg::MSTEPS_W-1:0] move_steps;
  logic [smseq_pkg::IV_W-1:0]     move_interval_us;
  logic                           last_step;

  modport source (output valid, status, fired_mask, coils_x, coils_y, coils_z,
                  move_steps, move_interval_us, last_step, input ready);
  modport sink   (input valid, status, fired_mask, coils_x, coils_y, coils_z,
                  move_steps, move_interval_us, last_step, output ready);
endinterface

`default_nettype wire

[src/stepper_move_sequencer.sv]
// Stepper move sequencer top level: per-axis step state, the move arithmetic
// and its shared restoring divider. Depends on smseq_pkg, smseq_in_if, smseq_out_if.
`default_nettype none

// Drives the full-step coils of up to AXES stepper axes from a stream of input
// words. A tick word is one microsecond of time: every running axis whose
// countdown has expired writes the coil pattern of its phase, moves its phase
// one way or the other and reloads its countdown; a result word comes out only
// when at least one axis stepped. A move word computes the step count with a
// single 24x8 multiply and the step interval with a 32-iteration restoring
// divider that retires one quotient bit per cycle, then reports accepted, zero
// move, too fast or busy. A release word switches every coil off but keeps the
// running moves. The block handles one input word at a time and is not ready
// while it works; a nonzero move spends most of its time in the divider.
// Finished results sit in an output register, so a new input word is taken
// while the previous result still waits; a word that needs to report while
// that register is still full holds its last cycle until the register drains.
module stepper_move_sequencer #(
  parameter int AXES            = 3,
  parameter int STEP_COUNT_BITS = 24
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  smseq_in_if.sink                             in_chan,
  smseq_out_if.source                          out_chan,
  input  wire                                  cfg_we,
  input  wire [smseq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [smseq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AXCMP_W = 4;
  localparam logic [32:0] STEP_MAX = (33'd1 << STEP_COUNT_BITS) - 33'd1;

  // Configuration registers.
  logic [smseq_pkg::SPM_W-1:0] spm_r;
  logic [smseq_pkg::US_W-1:0]  reject_r;
  logic [smseq_pkg::US_W-1:0]  min_iv_r;

  // Sequencer state.
  smseq_pkg::state_t state_r, state_nxt;

  // Per-axis step state.
  logic [smseq_pkg::PHASE_W-1:0] phase_r [AXES];
  logic [smseq_pkg::PHASE_W-1:0] phase_nxt [AXES];
  logic                          fwd_r [AXES];
  logic                          fwd_nxt [AXES];
  logic [STEP_COUNT_BITS-1:0]    left_r [AXES];
  logic [STEP_COUNT_BITS-1:0]    left_nxt [AXES];
  logic [smseq_pkg::IV_W-1:0]    iv_r [AXES];
  logic [smseq_pkg::IV_W-1:0]    iv_nxt [AXES];
  logic [smseq_pkg::IV_W-1:0]    cd_r [AXES];
  logic [smseq_pkg::IV_W-1:0]    cd_nxt [AXES];
  logic [smseq_pkg::COIL_W-1:0]  coil_r [AXES];
  logic [smseq_pkg::COIL_W-1:0]  coil_nxt [AXES];

  // Move datapath registers.
  logic [smseq_pkg::AXIS_W-1:0]    ax_r, ax_nxt;
  logic                            neg_r, neg_nxt;
  logic [smseq_pkg::DIST_W-1:0]    mag_r, mag_nxt;
  logic [smseq_pkg::DUR_W-1:0]     dur_r, dur_nxt;
  logic [smseq_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [smseq_pkg::N_W-1:0]       n_r, n_nxt;
  logic [smseq_pkg::STEPS_W-1:0]   steps_r, steps_nxt;
  logic [smseq_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [smseq_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [smseq_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [smseq_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  smseq_pkg::res_t   res_r, res_nxt;

  // Combinational helpers.
  logic                          in_accept;
  logic                          slot_free;
  logic                          emit;
  logic [smseq_pkg::DIST_W-1:0]  dist_u;
  logic [smseq_pkg::PROD_W-1:0]  rounded;
  logic [smseq_pkg::STEPS_W-1:0] steps_raw;
  logic [smseq_pkg::STEPS_W-1:0] steps_sat;
  logic [smseq_pkg::DVS_W:0]     rem_sh;
  logic                          rem_ge;
  logic [smseq_pkg::IV_W-1:0]    quot;
  logic [smseq_pkg::IV_W-1:0]    iv_raised;
  logic                          too_fast;
  logic [AXES-1:0]               hit;
  logic [AXES-1:0]               running;
  logic [AXES-1:0]               fire;
  logic                          busy;
  logic                          last_any;
  logic [smseq_pkg::FIRED_W-1:0] fired3;

  assign in_accept     = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == smseq_pkg::S_IDLE);
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign dist_u        = in_chan.distance_q8;

  // Step count: round half down of |d| * steps_per_mm / 256, then saturate.
  assign rounded   = prod_r + smseq_pkg::ROUND_BIAS;
  assign steps_raw = rounded[smseq_pkg::PROD_W-1:smseq_pkg::FRAC_BITS];
  assign steps_sat = (33'(steps_raw) > STEP_MAX) ? smseq_pkg::STEPS_W'(STEP_MAX)
                                                 : steps_raw;

  // One restoring-division step: bring down the next dividend bit.
  assign rem_sh = {rem_r, dvd_r[smseq_pkg::DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_r});

  // After the last step the dividend register holds the quotient, which never
  // exceeds 1000 * duration and so fits the interval width.
  assign quot      = dvd_r[smseq_pkg::IV_W-1:0];
  assign too_fast  = (quot < smseq_pkg::IV_W'(reject_r));
  assign iv_raised = (quot < smseq_pkg::IV_W'(min_iv_r)) ? smseq_pkg::IV_W'(min_iv_r) : quot;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      hit[i]     = ({2'b00, ax_r} == AXCMP_W'(i));
      running[i] = (left_r[i] != '0);
      fire[i]    = running[i] && (cd_r[i] == '0);
    end
    busy = |(hit & running);
  end

  always_comb begin
    state_nxt     = state_r;
    emit          = 1'b0;
    res_nxt       = res_r;
    ax_nxt        = ax_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    dur_nxt       = dur_r;
    prod_nxt      = prod_r;
    n_nxt         = n_r;
    steps_nxt     = steps_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    last_any      = 1'b0;
    fired3        = '0;
    for (int i = 0; i < AXES; i++) begin
      phase_nxt[i] = phase_r[i];
      fwd_nxt[i]   = fwd_r[i];
      left_nxt[i]  = left_r[i];
      iv_nxt[i]    = iv_r[i];
      cd_nxt[i]    = cd_r[i];
      coil_nxt[i]  = coil_r[i];
    end

    for (int i = 0; i < AXES; i++) begin
      if (fire[i] && (left_r[i] == STEP_COUNT_BITS'(1))) begin
        last_any = 1'b1;
      end
      if (i < smseq_pkg::OUT_AXES) begin
        fired3[i[1:0]] = fire[i];
      end
    end

    case (state_r)
      smseq_pkg::S_IDLE: begin
        if (in_accept) begin
          ax_nxt  = in_chan.axis;
          neg_nxt = dist_u[smseq_pkg::DIST_W-1];
          mag_nxt = dist_u[smseq_pkg::DIST_W-1] ? (~dist_u + 24'd1) : dist_u;
          dur_nxt = in_chan.duration_ms;
          case (smseq_pkg::kind_t'(in_chan.kind))
            smseq_pkg::KIND_TICK:    state_nxt = smseq_pkg::S_TICK;
            smseq_pkg::KIND_RELEASE: state_nxt = smseq_pkg::S_RELEASE;
            smseq_pkg::KIND_MOVE: begin
              // A move for an axis that is not built is dropped silently.
              if ({2'b00, in_chan.axis} < AXCMP_W'(AXES)) begin
                state_nxt = smseq_pkg::S_MULT;
              end
            end
            default: state_nxt = smseq_pkg::S_IDLE;
          endcase
        end
      end

      smseq_pkg::S_TICK: begin
        // Every axis advances in parallel; a tick with no step reports nothing.
        if (!(|fire) || slot_free) begin
          for (int i = 0; i < AXES; i++) begin
            if (fire[i]) begin
              coil_nxt[i]  = smseq_pkg::coil_of_phase(phase_r[i]);
              phase_nxt[i] = fwd_r[i] ? (phase_r[i] + 2'd1) : (phase_r[i] - 2'd1);
              left_nxt[i]  = left_r[i] - STEP_COUNT_BITS'(1);
              cd_nxt[i]    = (iv_r[i] == '0) ? '0 : (iv_r[i] - 30'd1);
            end else if (running[i]) begin
              cd_nxt[i] = cd_r[i] - 30'd1;
            end
          end
          emit             = |fire;
          res_nxt.status   = smseq_pkg::STAT_STEP;
          res_nxt.fired    = fired3;
          res_nxt.steps    = '0;
          res_nxt.interval = '0;
          res_nxt.last     = last_any;
          state_nxt        = smseq_pkg::S_IDLE;
        end
      end

      smseq_pkg::S_RELEASE: begin
        if (slot_free) begin
          for (int i = 0; i < AXES; i++) begin
            coil_nxt[i] = '0;
          end
          emit             = 1'b1;
          res_nxt.status   = smseq_pkg::STAT_RELEASED;
          res_nxt.fired    = '0;
          res_nxt.steps    = '0;
          res_nxt.interval = '0;
          res_nxt.last     = 1'b0;
          state_nxt        = smseq_pkg::S_IDLE;
        end
      end

      smseq_pkg::S_MULT: begin
        prod_nxt  = smseq_pkg::PROD_W'(mag_r) * smseq_pkg::PROD_W'(spm_r);
        n_nxt     = smseq_pkg::N_W'(dur_r) * smseq_pkg::US_PER_MS;
        state_nxt = smseq_pkg::S_SCALE;
      end

      smseq_pkg::S_SCALE: begin
        steps_nxt = steps_sat;
        if (steps_sat == '0) begin
          // Zero distance rounds to zero steps as well.
          if (slot_free) begin
            emit             = 1'b1;
            res_nxt.status   = smseq_pkg::STAT_ZERO;
            res_nxt.fired    = '0;
            res_nxt.steps    = '0;
            res_nxt.interval = '0;
            res_nxt.last     = 1'b0;
            state_nxt        = smseq_pkg::S_IDLE;
          end
        end else begin
          // Interval = (2N + steps - 1) / (2 * steps): round half down.
          dvd_nxt   = smseq_pkg::DVD_W'({n_r, 1'b0}) + smseq_pkg::DVD_W'(steps_sat)
                      - smseq_pkg::DVD_W'(1);
          dvs_nxt   = {steps_sat, 1'b0};
          rem_nxt   = '0;
          cnt_nxt   = smseq_pkg::DIV_CNT_W'(smseq_pkg::DVD_W - 1);
          state_nxt = smseq_pkg::S_DIV;
        end
      end

      smseq_pkg::S_DIV: begin
        rem_nxt = rem_ge ? smseq_pkg::DVS_W'(rem_sh - {1'b0, dvs_r})
                         : smseq_pkg::DVS_W'(rem_sh);
        dvd_nxt = {dvd_r[smseq_pkg::DVD_W-2:0], rem_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = smseq_pkg::S_DECIDE;
        end
      end

      smseq_pkg::S_DECIDE: begin
        if (slot_free) begin
          emit          = 1'b1;
          res_nxt.fired = '0;
          res_nxt.steps = steps_r;
          res_nxt.last  = 1'b0;
          if (too_fast) begin
            res_nxt.status   = smseq_pkg::STAT_TOO_FAST;
            res_nxt.interval = quot;
          end else if (busy) begin
            res_nxt.status   = smseq_pkg::STAT_BUSY;
            res_nxt.interval = iv_raised;
          end else begin
            res_nxt.status   = smseq_pkg::STAT_ACCEPTED;
            res_nxt.interval = iv_raised;
            for (int i = 0; i < AXES; i++) begin
              if (hit[i]) begin
                fwd_nxt[i]  = !neg_r;
                left_nxt[i] = STEP_COUNT_BITS'(steps_r);
                iv_nxt[i]   = iv_raised;
                cd_nxt[i]   = '0;
              end
            end
          end
          state_nxt = smseq_pkg::S_IDLE;
        end
      end

      default: state_nxt = smseq_pkg::S_IDLE;
    endcase

    // Coils are reported as they stand after the word; missing axes read as off.
    res_nxt.coils = '0;
    for (int i = 0; i < AXES; i++) begin
      if (i < smseq_pkg::OUT_AXES) begin
        res_nxt.coils[i[1:0]] = coil_nxt[i];
      end
    end

    out_valid_nxt = emit ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smseq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      spm_r       <= smseq_pkg::SPM_RESET;
      reject_r    <= smseq_pkg::REJECT_RESET;
      min_iv_r    <= smseq_pkg::MIN_RESET;
      for (int i = 0; i < AXES; i++) begin
        phase_r[i] <= '0;
        fwd_r[i]   <= 1'b1;
        left_r[i]  <= '0;
        iv_r[i]    <= '0;
        cd_r[i]    <= '0;
        coil_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          smseq_pkg::CFG_STEPS_PER_MM: spm_r    <= cfg_wdata[smseq_pkg::SPM_W-1:0];
          smseq_pkg::CFG_REJECT_BELOW: reject_r <= cfg_wdata[smseq_pkg::US_W-1:0];
          smseq_pkg::CFG_MIN_INTERVAL: min_iv_r <= cfg_wdata[smseq_pkg::US_W-1:0];
          default: begin
          end
        endcase
      end
      for (int i = 0; i < AXES; i++) begin
        phase_r[i] <= phase_nxt[i];
        fwd_r[i]   <= fwd_nxt[i];
        left_r[i]  <= left_nxt[i];
        iv_r[i]    <= iv_nxt[i];
        cd_r[i]    <= cd_nxt[i];
        coil_r[i]  <= coil_nxt[i];
      end
    end
  end

  // Datapath and result registers carry no reset.
  always_ff @(posedge clk) begin
    ax_r    <= ax_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    dur_r   <= dur_nxt;
    prod_r  <= prod_nxt;
    n_r     <= n_nxt;
    steps_r <= steps_nxt;
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = res_r.status;
  assign out_chan.fired_mask       = res_r.fired;
  assign out_chan.coils_x          = res_r.coils[0];
  assign out_chan.coils_y          = res_r.coils[1];
  assign out_chan.coils_z          = res_r.coils[2];
  assign out_chan.move_steps       = res_r.steps;
  assign out_chan.move_interval_us = res_r.interval;
  assign out_chan.last_step        = res_r.last;

endmodule

`default_nettype wire
